>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define AST_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/csrmv_pkg.sv
// csrmv_pkg: shared types and constants of the sparse matrix vector multiply
`timescale 1ns / 1ps
package csrmv_pkg;

	localparam int VECTOR_DEPTH = 1024;
	localparam int VEC_AW = $clog2(VECTOR_DEPTH);
	localparam int CMP_W = 18;

	localparam int LEN_W = 11;
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

	// operation codes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_NONZERO = 2'd1;
	localparam logic [1:0] OP_END_ROW = 2'd2;

	// work queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int QSUM_W = QCNT_W + 1;

	// result queue inside the back end
	localparam int ODEPTH = 4;
	localparam int OPTR_W = $clog2(ODEPTH);
	localparam int OCNT_W = $clog2(ODEPTH + 1);
	localparam int OSUM_W = OCNT_W + 1;

	typedef struct packed {
		logic [1:0] operation;
		logic [9:0] vector_index;
		logic [9:0] column;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] row_sum;
		logic [15:0] row_number;
		logic column_error;
		logic saturated;
	} out_item_t;

	typedef struct packed {
		logic is_end;
		logic col_err;
		logic signed [31:0] value;
		logic signed [31:0] element;
	} work_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic avail;
	} qstat_t;

endpackage

>>> rtl/csr_sparse_matrix_vector_multiply.sv
// csr_sparse_matrix_vector_multiply: top level of the sparse row times vector unit
`timescale 1ns / 1ps
// usage
// - request channel (push/full): an item is taken on a clock edge with push high and
//   full low; operation selects load of a vector element, a nonzero (column, value)
//   of the current row, or end of row; code 3 is dropped
// - result channel (empty/pop): one item per end of row, holding the q16.16 row sum,
//   the row number, a column error flag and a saturation flag; the oldest item is
//   shown while empty is low and leaves on an edge with pop high
// - cfg_we/cfg_wdata write vector_length; write it only while the block is idle
// - throughput: one item per cycle sustained while results are popped, a single
//   32x32 multiplier in the back end and one store port per cycle in the front end
// - a result goes via front s1, work queue, back s1 and result queue to the ports
// - a stalled receiver fills the 4-entry result queue, then the 4-entry work queue,
//   after which full goes high; nothing is lost or repeated
// - reset clears the row sum, flags, row counter and queues and sets vector_length to
//   1024; the vector store is not cleared and must be loaded before use
module csr_sparse_matrix_vector_multiply (
	input  logic                         clk,
	input  logic                         arst_n,
	// request side
	input  logic                         push,
	output logic                         full,
	input  csrmv_pkg::in_item_t          request,
	// result side
	output logic                         empty,
	input  logic                         pop,
	output csrmv_pkg::out_item_t         result,
	// configuration
	input  logic                         cfg_we,
	input  logic [csrmv_pkg::LEN_W-1:0]  cfg_wdata
);

	logic [csrmv_pkg::LEN_W-1:0] vector_length_q;

	// work queue wires
	logic q_push;
	logic q_pop;
	csrmv_pkg::work_t q_in;
	csrmv_pkg::work_t q_head;
	csrmv_pkg::qstat_t q_stat;

	// vector length register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_length_q <= csrmv_pkg::LEN_RESET;
		end else if (cfg_we) begin
			vector_length_q <= cfg_wdata;
		end
	end

	// front end: handshake, store writes and reads, column range check
	csrmv_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.request       (request),
		.vector_length (vector_length_q),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_item        (q_in)
	);

	// decouples the store read from the multiply-accumulate
	csrmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	// back end: product, saturating accumulate, narrowing, result queue
	csrmv_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_item (q_head),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

>>> rtl/csrmv_ram.sv
// csrmv_ram: generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module csrmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/csrmv_queue.sv
// csrmv_queue: short work queue between the front and back ends
`timescale 1ns / 1ps
module csrmv_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csrmv_pkg::work_t   push_item,
	input  logic               pop,
	output csrmv_pkg::work_t   head,
	output csrmv_pkg::qstat_t  stat
);

	csrmv_pkg::work_t mem_q [csrmv_pkg::QDEPTH];
	logic [csrmv_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [csrmv_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [csrmv_pkg::QCNT_W-1:0] count_q;

	function automatic logic [csrmv_pkg::QPTR_W-1:0] next_ptr(
		input logic [csrmv_pkg::QPTR_W-1:0] p
	);
		if (p == csrmv_pkg::QPTR_W'(csrmv_pkg::QDEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.avail = (count_q != '0);

endmodule

>>> rtl/csrmv_front.sv
// csrmv_front: accepts items, owns the vector store, classifies work
`timescale 1ns / 1ps
module csrmv_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  csrmv_pkg::in_item_t             request,
	input  logic [csrmv_pkg::LEN_W-1:0]     vector_length,
	input  csrmv_pkg::qstat_t               q_stat,
	output logic                            q_push,
	output csrmv_pkg::work_t                q_item
);

	logic accept;
	logic [csrmv_pkg::QSUM_W-1:0] in_flight;
	logic [csrmv_pkg::CMP_W-1:0] len_eff;
	logic col_ok;
	logic load_ok;
	logic store_we;
	logic [31:0] element;

	logic valid_s1;
	logic is_end_s1;
	logic err_s1;
	logic signed [31:0] value_s1;

	// queue slots already spoken for, including the item in s1
	assign in_flight = csrmv_pkg::QSUM_W'(q_stat.count) + csrmv_pkg::QSUM_W'(valid_s1);
	assign full = (in_flight >= csrmv_pkg::QSUM_W'(csrmv_pkg::QDEPTH));
	assign accept = push && !full;

	always_comb begin
		if (csrmv_pkg::CMP_W'(vector_length) > csrmv_pkg::CMP_W'(csrmv_pkg::VECTOR_DEPTH)) begin
			len_eff = csrmv_pkg::CMP_W'(csrmv_pkg::VECTOR_DEPTH);
		end else begin
			len_eff = csrmv_pkg::CMP_W'(vector_length);
		end
	end

	assign col_ok = (csrmv_pkg::CMP_W'(request.column) < len_eff);
	assign load_ok = (csrmv_pkg::CMP_W'(request.vector_index)
		< csrmv_pkg::CMP_W'(csrmv_pkg::VECTOR_DEPTH));
	assign store_we = accept && (request.operation == csrmv_pkg::OP_LOAD) && load_ok;

	csrmv_ram #(
		.WIDTH(32),
		.DEPTH(csrmv_pkg::VECTOR_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (csrmv_pkg::VEC_AW'(request.vector_index)),
		.wdata (request.value),
		.raddr (csrmv_pkg::VEC_AW'(request.column)),
		.rdata (element)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && ((request.operation == csrmv_pkg::OP_NONZERO)
				|| (request.operation == csrmv_pkg::OP_END_ROW));
		end
	end

	always_ff @(posedge clk) begin
		is_end_s1 <= (request.operation == csrmv_pkg::OP_END_ROW);
		err_s1 <= !col_ok;
		value_s1 <= request.value;
	end

	assign q_push = valid_s1;
	assign q_item.is_end = is_end_s1;
	assign q_item.col_err = err_s1 && !is_end_s1;
	assign q_item.value = value_s1;
	assign q_item.element = element;

endmodule

>>> rtl/csrmv_back.sv
// csrmv_back: multiply, saturating row accumulation, narrowing, result queue
`timescale 1ns / 1ps
module csrmv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csrmv_pkg::qstat_t     q_stat,
	input  csrmv_pkg::work_t      q_item,
	output logic                  q_pop,
	output logic                  empty,
	input  logic                  pop,
	output csrmv_pkg::out_item_t  result
);

	localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

	logic [csrmv_pkg::OSUM_W-1:0] o_sum;

	logic valid_s1;
	logic is_end_s1;
	logic err_s1;
	logic signed [63:0] prod_s1;

	logic signed [63:0] acc_q;
	logic err_q;
	logic sat_q;
	logic [15:0] row_q;

	logic [64:0] add_ext;
	logic add_ovf;
	logic signed [63:0] acc_next;
	logic do_acc;
	logic res_push;
	logic in_range;
	csrmv_pkg::out_item_t res_item;

	csrmv_pkg::out_item_t omem_q [csrmv_pkg::ODEPTH];
	logic [csrmv_pkg::OPTR_W-1:0] owr_q;
	logic [csrmv_pkg::OPTR_W-1:0] ord_q;
	logic [csrmv_pkg::OCNT_W-1:0] ocount_q;
	logic out_pop;

	function automatic logic [csrmv_pkg::OPTR_W-1:0] next_ptr(
		input logic [csrmv_pkg::OPTR_W-1:0] p
	);
		if (p == csrmv_pkg::OPTR_W'(csrmv_pkg::ODEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	// take work only while the result queue has room for what is in flight
	assign o_sum = csrmv_pkg::OSUM_W'(ocount_q) + csrmv_pkg::OSUM_W'(valid_s1);
	assign q_pop = q_stat.avail && (o_sum < csrmv_pkg::OSUM_W'(csrmv_pkg::ODEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		is_end_s1 <= q_item.is_end;
		err_s1 <= q_item.col_err;
		prod_s1 <= q_item.value * q_item.element;
	end

	// saturating 64-bit add
	assign add_ext = {acc_q[63], acc_q} + {prod_s1[63], prod_s1};
	assign add_ovf = (add_ext[64] != add_ext[63]);
	always_comb begin
		if (add_ovf) begin
			acc_next = add_ext[64] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_next = add_ext[63:0];
		end
	end

	assign do_acc = valid_s1 && !is_end_s1 && !err_s1;
	assign res_push = valid_s1 && is_end_s1;

	// q32.32 to q16.16: in range when bits 63..47 all match the sign
	assign in_range = (&acc_q[63:47]) || !(|acc_q[63:47]);
	always_comb begin
		if (in_range) begin
			res_item.row_sum = acc_q[47:16];
		end else if (acc_q[63]) begin
			res_item.row_sum = 32'sh8000_0000;
		end else begin
			res_item.row_sum = 32'sh7fff_ffff;
		end
		res_item.row_number = row_q;
		res_item.column_error = err_q;
		res_item.saturated = sat_q || !in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= 1'b0;
			sat_q <= 1'b0;
			row_q <= '0;
		end else if (res_push) begin
			acc_q <= '0;
			err_q <= 1'b0;
			sat_q <= 1'b0;
			row_q <= row_q + 1'b1;
		end else if (valid_s1) begin
			if (err_s1) begin
				err_q <= 1'b1;
			end
			if (do_acc) begin
				acc_q <= acc_next;
				if (add_ovf) begin
					sat_q <= 1'b1;
				end
			end
		end
	end

	// result queue
	assign out_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (res_push) begin
			omem_q[owr_q] <= res_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q <= '0;
			ord_q <= '0;
			ocount_q <= '0;
		end else begin
			if (res_push) begin
				owr_q <= next_ptr(owr_q);
			end
			if (out_pop) begin
				ord_q <= next_ptr(ord_q);
			end
			case ({res_push, out_pop})
				2'b10: ocount_q <= ocount_q + 1'b1;
				2'b01: ocount_q <= ocount_q - 1'b1;
				default: ocount_q <= ocount_q;
			endcase
		end
	end

	assign empty = (ocount_q == '0);
	assign result = omem_q[ord_q];

endmodule

>>> rtl/csrmv_checker.sv
// csrmv_checker: port-level checks on the top level, attached by bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module csrmv_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input logic                  full,
	input csrmv_pkg::in_item_t   request,
	input logic                  empty,
	input logic                  pop,
	input csrmv_pkg::out_item_t  result
);

	logic [7:0] pending_q;
	logic [15:0] exp_row_q;
	logic end_in;
	logic res_out;

	assign end_in = push && !full && (request.operation == csrmv_pkg::OP_END_ROW);
	assign res_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			exp_row_q <= '0;
		end else begin
			case ({end_in, res_out})
				2'b10: pending_q <= pending_q + 1'b1;
				2'b01: pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
			if (res_out) begin
				exp_row_q <= exp_row_q + 1'b1;
			end
		end
	end

	// every shown result stems from an end of row item
	`AST_IMPLY(a_no_invented, !empty, pending_q != 8'd0)

	// rows leave in order, numbered from zero after reset
	`AST_IMPLY(a_row_order, res_out, result.row_number == exp_row_q)

	// a waiting result stays put until taken
	`AST_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))

endmodule

bind csr_sparse_matrix_vector_multiply csrmv_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.push    (push),
	.full    (full),
	.request (request),
	.empty   (empty),
	.pop     (pop),
	.result  (result)
);
